// ===== sv/tip_pkg.sv =====
// shared types, constants and codes of the table interpolator
package tip_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = 2 * VAL_W;

    localparam logic [1:0] REG_INTERP = 2'd0;
    localparam logic [1:0] REG_EXTRAP = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    localparam logic [1:0] INTERP_LINEAR = 2'd0;
    localparam logic [1:0] INTERP_LOWER  = 2'd1;
    localparam logic [1:0] INTERP_UPPER  = 2'd2;

    localparam logic [1:0] EXTRAP_HOLD   = 2'd0;
    localparam logic [1:0] EXTRAP_LINEAR = 2'd1;
    localparam logic [1:0] EXTRAP_FLAG   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_ORDER     = 3'd3;
    localparam logic [2:0] ST_SATURATED = 3'd4;

    localparam logic KIND_LOAD = 1'b0;

    typedef enum logic [2:0] {
        OP_LOAD_DIRECT,
        OP_LOAD_CHECK,
        OP_EMPTY,
        OP_SINGLE,
        OP_SEARCH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  px;
        logic [VAL_W-1:0]  py;
        logic [VAL_W-1:0]  qx;
        logic [CNT_W-1:0]  n;
        logic [1:0]        em;
        logic [1:0]        im;
    } cmd_t;

endpackage

// ===== sv/table_interpolator_1d.sv =====
// top level of the one-dimensional piecewise-linear table interpolator
// Table of up to 64 Q16.16 breakpoints; a load request writes one point (rejected with
// status 3 unless its x is above the previous entry's), a query request returns the
// blend, step or upper value, or the extrapolated / flagged value out of range. One
// result per request, in order. Requests queue two deep ahead of the back end and one
// result waits in the output register, so the input keeps taking requests while a
// result is not yet popped. The back end works one request at a time; a step or blend
// query inside the table range first finds its interval by binary search, and a linear
// extrapolation or linear blend then runs the 64-step bit-serial divider of the
// rounding division. The table memory has a single read port, one probe per search
// step. No clearing pass runs after reset; entries never written read as unknown.
module table_interpolator_1d (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    // request side
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [5:0]  entry_index,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] query_x,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [31:0] result_value,
    output logic [2:0]  status
);

    tip_pkg::cmd_t front_cmd;
    tip_pkg::cmd_t queue_cmd;
    logic          queue_empty;
    logic          queue_pop;

    // config registers and request classification
    tip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .entry_index (entry_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .query_x     (query_x),
        .cmd         (front_cmd)
    );

    // decouples acceptance from the long back-end work
    tip_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cmd),
        .full  (full),
        .pop   (queue_pop),
        .dout  (queue_cmd),
        .empty (queue_empty)
    );

    // table memory, search, arithmetic and result register
    tip_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (queue_empty),
        .q_data       (queue_cmd),
        .q_pop        (queue_pop),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .status       (status)
    );

endmodule

// ===== sv/tip_front.sv =====
// front end: configuration registers and classification of incoming requests
module tip_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [6:0]                 cfg_data,
    input  logic                       kind,
    input  logic [tip_pkg::IDX_W-1:0]  entry_index,
    input  logic [31:0]                point_x,
    input  logic [31:0]                point_y,
    input  logic [31:0]                query_x,
    output tip_pkg::cmd_t              cmd
);

    logic [1:0]                interp_reg;
    logic [1:0]                extrap_reg;
    logic [tip_pkg::CNT_W-1:0] count_reg;
    logic [tip_pkg::CNT_W-1:0] n_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg <= '0;
            extrap_reg <= '0;
            count_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tip_pkg::REG_INTERP: interp_reg <= cfg_data[1:0];
                tip_pkg::REG_EXTRAP: extrap_reg <= cfg_data[1:0];
                tip_pkg::REG_COUNT:  count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp count and fold unused mode codes
    assign n_eff = (count_reg > tip_pkg::CNT_W'(tip_pkg::MAX_POINTS))
                 ? tip_pkg::CNT_W'(tip_pkg::MAX_POINTS) : count_reg;

    always_comb
    begin
        cmd.idx = entry_index;
        cmd.px  = point_x;
        cmd.py  = point_y;
        cmd.qx  = query_x;
        cmd.n   = n_eff;
        cmd.em  = (extrap_reg == 2'd3) ? tip_pkg::EXTRAP_HOLD : extrap_reg;
        cmd.im  = (interp_reg == 2'd3) ? tip_pkg::INTERP_LINEAR : interp_reg;
        if (kind == tip_pkg::KIND_LOAD)
            cmd.op = (entry_index == '0) ? tip_pkg::OP_LOAD_DIRECT : tip_pkg::OP_LOAD_CHECK;
        else if (n_eff == '0)
            cmd.op = tip_pkg::OP_EMPTY;
        else if (n_eff == tip_pkg::CNT_W'(1))
            cmd.op = tip_pkg::OP_SINGLE;
        else
            cmd.op = tip_pkg::OP_SEARCH;
    end

endmodule

// ===== sv/tip_cmd_queue.sv =====
// two-entry request queue between front end and back end
module tip_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tip_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output tip_pkg::cmd_t dout,
    output logic          empty
);

    tip_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== sv/tip_back.sv =====
// back end: table memories, binary search, multiply, serial divide, result register
module tip_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  tip_pkg::cmd_t q_data,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   result_value,
    output logic [2:0]    status
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_LDCHK, S_ONE, S_Q0, S_QN, S_LO, S_HI,
        S_SRCH, S_EVAL, S_MUL, S_ADDH, S_DIV, S_FIN, S_DONE
    } state_t;

    localparam int IW = tip_pkg::IDX_W;
    localparam int PW = tip_pkg::PROD_W;

    logic [31:0] x_mem [tip_pkg::MAX_POINTS];
    logic [31:0] y_mem [tip_pkg::MAX_POINTS];

    state_t        state_reg, state_next;
    tip_pkg::cmd_t cmd_reg, cmd_next;
    logic [31:0]   xl_reg, xl_next, yl_reg, yl_next;
    logic [31:0]   xh_reg, xh_next, yh_reg, yh_next;
    logic [IW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic          below_reg, below_next;
    logic          neg_reg, neg_next;
    logic [31:0]   w_reg, w_next;
    logic [PW-1:0] dvd_reg, dvd_next;
    logic [31:0]   rem_reg, rem_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [31:0]   val_reg, val_next;
    logic [2:0]    stat_reg, stat_next;
    logic          res_valid_reg, res_valid_next;
    logic [31:0]   res_value_reg, res_value_next;
    logic [2:0]    res_status_reg, res_status_next;

    logic [31:0]   x_rd_reg, y_rd_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;

    logic signed [32:0] dy, dd, dw;
    logic [31:0]        mdy, mdd;
    logic [IW:0]        mid_sum;
    logic [IW-1:0]      nm1, nm2;
    logic [32:0]        rem_sh;
    logic               qbit;
    logic               sat_big;
    logic signed [35:0] total;

    assign empty        = !res_valid_reg;
    assign result_value = res_value_reg;
    assign status       = res_status_reg;
    assign nm1          = IW'(cmd_reg.n - 7'd1);
    assign nm2          = IW'(cmd_reg.n - 7'd2);

    // table memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[cmd_reg.idx] <= cmd_reg.px;
            y_mem[cmd_reg.idx] <= cmd_reg.py;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    always_comb
    begin
        dy     = $signed({yh_reg[31], yh_reg}) - $signed({yl_reg[31], yl_reg});
        dd     = $signed({cmd_reg.qx[31], cmd_reg.qx}) - $signed({xl_reg[31], xl_reg});
        dw     = $signed({xh_reg[31], xh_reg}) - $signed({xl_reg[31], xl_reg});
        mdy    = dy[32] ? 32'(-dy) : dy[31:0];
        mdd    = dd[32] ? 32'(-dd) : dd[31:0];
        rem_sh = {rem_reg, dvd_reg[PW-1]};
        qbit   = (rem_sh >= {1'b0, w_reg});
        sat_big = (|dvd_reg[PW-1:35]) || (dvd_reg[34] && (|dvd_reg[33:0]));
        total  = neg_reg ? ($signed({{4{yl_reg[31]}}, yl_reg}) - $signed({1'b0, dvd_reg[34:0]}))
                         : ($signed({{4{yl_reg[31]}}, yl_reg}) + $signed({1'b0, dvd_reg[34:0]}));

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        xl_next         = xl_reg;
        yl_next         = yl_reg;
        xh_next         = xh_reg;
        yh_next         = yh_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        below_next      = below_reg;
        neg_next        = neg_reg;
        w_next          = w_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        val_next        = val_reg;
        stat_next       = stat_reg;
        res_valid_next  = res_valid_reg && !pop;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        q_pop           = 1'b0;
        mid_sum         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                val_next  = '0;
                stat_next = tip_pkg::ST_OK;
                case (cmd_reg.op)
                    tip_pkg::OP_LOAD_DIRECT:
                    begin
                        wr_en      = 1'b1;
                        state_next = S_DONE;
                    end
                    tip_pkg::OP_LOAD_CHECK:
                    begin
                        rd_addr    = cmd_reg.idx - IW'(1);
                        state_next = S_LDCHK;
                    end
                    tip_pkg::OP_EMPTY:
                    begin
                        stat_next  = tip_pkg::ST_EMPTY;
                        state_next = S_DONE;
                    end
                    tip_pkg::OP_SINGLE:
                        state_next = S_ONE;
                    default:
                        state_next = S_Q0;
                endcase
            end
            S_LDCHK:
            begin
                if ($signed(cmd_reg.px) <= $signed(x_rd_reg))
                    stat_next = tip_pkg::ST_ORDER;
                else
                    wr_en = 1'b1;
                state_next = S_DONE;
            end
            S_ONE:
            begin
                if (cmd_reg.em == tip_pkg::EXTRAP_FLAG && cmd_reg.qx != x_rd_reg)
                    stat_next = tip_pkg::ST_RANGE;
                else
                    val_next = y_rd_reg;
                state_next = S_DONE;
            end
            S_Q0:
            begin
                // first entry in hand, fetch the last
                xl_next    = x_rd_reg;
                yl_next    = y_rd_reg;
                below_next = $signed(cmd_reg.qx) < $signed(x_rd_reg);
                rd_addr    = nm1;
                state_next = S_QN;
            end
            S_QN:
            begin
                xh_next = x_rd_reg;
                yh_next = y_rd_reg;
                lo_next = '0;
                hi_next = nm1;
                if (below_reg || $signed(cmd_reg.qx) > $signed(x_rd_reg))
                begin
                    case (cmd_reg.em)
                        tip_pkg::EXTRAP_LINEAR:
                        begin
                            if ($signed(cmd_reg.qx) > $signed(x_rd_reg))
                            begin
                                rd_addr    = nm2;
                                state_next = S_LO;
                            end
                            else
                            begin
                                rd_addr    = IW'(1);
                                state_next = S_HI;
                            end
                        end
                        tip_pkg::EXTRAP_FLAG:
                        begin
                            stat_next  = tip_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            val_next   = below_reg ? yl_reg : y_rd_reg;
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (nm1 > IW'(1))
                begin
                    mid_sum    = {1'b0, nm1} >> 1;
                    rd_addr    = mid_sum[IW-1:0];
                    state_next = S_SRCH;
                end
                else
                    state_next = S_EVAL;
            end
            S_LO:
            begin
                xl_next    = x_rd_reg;
                yl_next    = y_rd_reg;
                state_next = S_MUL;
            end
            S_HI:
            begin
                xh_next    = x_rd_reg;
                yh_next    = y_rd_reg;
                state_next = S_MUL;
            end
            S_SRCH:
            begin
                // probe at the midpoint of the current bracket
                mid_sum = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
                if ($signed(x_rd_reg) <= $signed(cmd_reg.qx))
                begin
                    lo_next = mid_sum[IW-1:0];
                    xl_next = x_rd_reg;
                    yl_next = y_rd_reg;
                end
                else
                begin
                    hi_next = mid_sum[IW-1:0];
                    xh_next = x_rd_reg;
                    yh_next = y_rd_reg;
                end
                if (hi_next - lo_next > IW'(1))
                begin
                    mid_sum    = ({1'b0, lo_next} + {1'b0, hi_next}) >> 1;
                    rd_addr    = mid_sum[IW-1:0];
                end
                else
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                if (dd <= 0)
                    val_next = yl_reg;
                else if (dd >= dw)
                    val_next = yh_reg;
                else if (cmd_reg.im == tip_pkg::INTERP_LOWER)
                    val_next = yl_reg;
                else if (cmd_reg.im == tip_pkg::INTERP_UPPER)
                    val_next = yh_reg;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (dw <= 0 || dy == 0 || dd == 0)
                begin
                    val_next   = yl_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    dvd_next   = PW'(mdy) * PW'(mdd);
                    neg_next   = dy[32] != dd[32];
                    w_next     = dw[31:0];
                    state_next = S_ADDH;
                end
            end
            S_ADDH:
            begin
                // add half the divisor for round to nearest
                dvd_next   = dvd_reg + PW'(w_reg >> 1);
                rem_next   = '0;
                cnt_next   = 7'(PW);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = qbit ? 32'(rem_sh - {1'b0, w_reg}) : rem_sh[31:0];
                dvd_next = {dvd_reg[PW-2:0], qbit};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sat_big || total > 36'sh07FFFFFFF || total < -36'sh080000000)
                begin
                    stat_next = tip_pkg::ST_SATURATED;
                    val_next  = (sat_big ? neg_reg : total[35]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                    val_next = total[31:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_valid_next  = 1'b1;
                    res_value_next  = val_reg;
                    res_status_next = stat_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        xl_reg         <= xl_next;
        yl_reg         <= yl_next;
        xh_reg         <= xh_next;
        yh_reg         <= yh_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        below_reg      <= below_next;
        neg_reg        <= neg_next;
        w_reg          <= w_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        val_reg        <= val_next;
        stat_reg       <= stat_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

endmodule

// ===== bench/tb.sv =====
// self-checking testbench of the one-dimensional table interpolator
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        KIND_QUERY  = 1'b1;
    localparam longint      VAL_MAX     = 64'sd2147483647;
    localparam longint      VAL_MIN     = -64'sd2147483648;
    localparam logic [31:0] X_MIN       = 32'h8000_0000;
    localparam logic [31:0] X_MAX       = 32'h7fff_ffff;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          N_DIRECTED  = 36;

    // one row of the directed table: a config write, a load or a query
    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

    typedef struct {
        row_kind_t   rk;
        logic [5:0]  idx;
        logic [31:0] a;      // cfg: interp mode, load: point x
        logic [31:0] b;      // cfg: extrap mode, load: point y
        logic [31:0] c;      // cfg: point count, query: query x
        bit          known;  // expected result typed in below
        logic [31:0] val;
        logic [2:0]  st;
    } stim_row_t;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  st;
    } interp_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        push;
    logic        full;
    logic        kind;
    logic [5:0]  entry_index;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] query_x;
    logic        empty;
    logic        pop;
    logic [31:0] result_value;
    logic [2:0]  status;

    table_interpolator_1d u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .entry_index  (entry_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .query_x      (query_x),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .status       (status)
    );

    // predictor copy of the breakpoint table and the registers
    logic signed [31:0] tbl_x [tip_pkg::MAX_POINTS];
    logic signed [31:0] tbl_y [tip_pkg::MAX_POINTS];
    bit                 written [tip_pkg::MAX_POINTS];
    logic [1:0]         cur_interp;
    logic [1:0]         cur_extrap;
    logic [6:0]         cur_count;

    interp_result_t pending_results [$];
    bit             failed;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_request;
    int             cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("table_interpolator_1d regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
    always @(posedge clk)
    begin : recv_drive
        int hold_seen;
        int hold_left;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: result_value %h status %0d", result_value, status);
                failed = 1'b1;
            end
            else
            begin
                if (result_value !== pending_results[0].value)
                begin
                    $error("result_value: expected %h, actual %h",
                           pending_results[0].value, result_value);
                    failed = 1'b1;
                end
                if (status !== pending_results[0].st)
                begin
                    $error("status: expected %0d, actual %0d", pending_results[0].st, status);
                    failed = 1'b1;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // rounded blend y_lo + dy * d / w, saturated; returns {saturated, value}
    function automatic logic [32:0] blend_q16(input longint ylo, input longint yhi,
                                              input longint d, input longint w);
        longint          dy = yhi - ylo;
        longint unsigned mdy;
        longint unsigned md;
        longint unsigned prod;
        longint unsigned quo;
        longint          total;
        bit              neg;
        if (w <= 0 || dy == 0 || d == 0)
            return {1'b0, ylo[31:0]};
        mdy  = (dy < 0) ? -dy : dy;
        md   = (d < 0) ? -d : d;
        prod = mdy * md;
        quo  = (prod + (longint'(w) >> 1)) / w;
        neg  = (dy < 0) != (d < 0);
        if (quo > (64'd1 << 34))
            return neg ? {1'b1, VAL_MIN[31:0]} : {1'b1, VAL_MAX[31:0]};
        total = neg ? ylo - longint'(quo) : ylo + longint'(quo);
        if (total > VAL_MAX)
            return {1'b1, VAL_MAX[31:0]};
        if (total < VAL_MIN)
            return {1'b1, VAL_MIN[31:0]};
        return {1'b0, total[31:0]};
    endfunction

    // evaluates one request against the predictor table; loads update it
    function automatic interp_result_t interpolate(input logic k, input logic [5:0] idx,
                                                   input logic [31:0] px, input logic [31:0] py,
                                                   input logic [31:0] qx);
        interp_result_t r;
        int             n;
        int             lo;
        int             hi;
        int             mid;
        longint         q;
        longint         xl;
        longint         yl;
        longint         yh;
        longint         d;
        longint         w;
        bit             below;
        bit             above;
        bit             sat;
        logic [1:0]     em;
        logic [1:0]     im;
        r.value = '0;
        r.st    = tip_pkg::ST_OK;
        sat     = 1'b0;
        if (k == tip_pkg::KIND_LOAD)
        begin
            if (idx > 0 && $signed(px) <= tbl_x[idx - 1])
            begin
                r.st = tip_pkg::ST_ORDER;
            end
            else
            begin
                tbl_x[idx]   = px;
                tbl_y[idx]   = py;
                written[idx] = 1'b1;
            end
            return r;
        end
        n  = (cur_count > tip_pkg::MAX_POINTS) ? tip_pkg::MAX_POINTS : cur_count;
        em = (cur_extrap == 2'd3) ? tip_pkg::EXTRAP_HOLD : cur_extrap;
        im = (cur_interp == 2'd3) ? tip_pkg::INTERP_LINEAR : cur_interp;
        q  = longint'($signed(qx));
        if (n == 0)
        begin
            r.st = tip_pkg::ST_EMPTY;
        end
        else if (n == 1)
        begin
            // single point: constant, but flag mode rejects anything but its own x
            if (em == tip_pkg::EXTRAP_FLAG && q != tbl_x[0])
                r.st = tip_pkg::ST_RANGE;
            else
                r.value = tbl_y[0];
        end
        else
        begin
            below = q < tbl_x[0];
            above = q > tbl_x[n - 1];
            lo    = 0;
            hi    = n - 1;
            if (above)
            begin
                lo = n - 2;
            end
            else if (!below)
            begin
                while (hi - lo > 1)
                begin
                    mid = (lo + hi) / 2;
                    if (tbl_x[mid] <= q)
                        lo = mid;
                    else
                        hi = mid;
                end
            end
            xl = tbl_x[lo];
            yl = tbl_y[lo];
            yh = tbl_y[lo + 1];
            d  = q - xl;
            w  = longint'(tbl_x[lo + 1]) - xl;
            if (below || above)
            begin
                if (em == tip_pkg::EXTRAP_HOLD)
                    r.value = below ? tbl_y[0] : tbl_y[n - 1];
                else if (em == tip_pkg::EXTRAP_LINEAR)
                    {sat, r.value} = blend_q16(yl, yh, d, w);
                else
                    r.st = tip_pkg::ST_RANGE;
            end
            else if (d <= 0)
            begin
                r.value = yl[31:0];
            end
            else if (d >= w)
            begin
                r.value = yh[31:0];
            end
            else if (im == tip_pkg::INTERP_LOWER)
            begin
                r.value = yl[31:0];
            end
            else if (im == tip_pkg::INTERP_UPPER)
            begin
                r.value = yh[31:0];
            end
            else
            begin
                {sat, r.value} = blend_q16(yl, yh, d, w);
            end
            if (sat)
                r.st = tip_pkg::ST_SATURATED;
        end
        return r;
    endfunction

    // number of entries written without a hole, counted from entry 0
    function automatic int written_prefix();
        int i;
        for (i = 0; i < tip_pkg::MAX_POINTS; i++)
            if (!written[i])
                return i;
        return tip_pkg::MAX_POINTS;
    endfunction

    // offers one request, keeping push high across back-to-back requests
    task automatic send_request(input logic k, input logic [5:0] idx, input logic [31:0] px,
                                input logic [31:0] py, input logic [31:0] qx,
                                input bit known = 1'b0, input logic [31:0] kval = '0,
                                input logic [2:0] kst = tip_pkg::ST_OK);
        interp_result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        push        <= 1'b1;
        kind        <= k;
        entry_index <= idx;
        point_x     <= px;
        point_y     <= py;
        query_x     <= qx;
        do
            @(posedge clk);
        while (full);
        r = interpolate(k, idx, px, py, qx);
        if (known)
        begin
            r.value = kval;
            r.st    = kst;
        end
        pending_results.push_back(r);
    endtask

    // sender pause: stop offering and wait for every outstanding result
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // writes all three registers while the block is idle
    task automatic set_config(input logic [1:0] im, input logic [1:0] em, input logic [6:0] n);
        int i;
        drain();
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            case (i)
                0:
                begin
                    cfg_index <= tip_pkg::REG_INTERP;
                    cfg_data  <= {5'd0, im};
                end
                1:
                begin
                    cfg_index <= tip_pkg::REG_EXTRAP;
                    cfg_data  <= {5'd0, em};
                end
                default:
                begin
                    cfg_index <= tip_pkg::REG_COUNT;
                    cfg_data  <= n;
                end
            endcase
            do
                @(posedge clk);
            while (!cfg_ready);
            case (i)
                0: cur_interp = im;
                1: cur_extrap = em;
                default: cur_count = n;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    stim_row_t directed_rows [N_DIRECTED];

    initial
    begin
        int              r;
        int              ph;
        int              j;
        int              k;
        int              n;
        int              i;
        int              lim;
        int unsigned     step_max;
        longint          slack;
        longint          cur_x;
        logic [31:0]     qx;
        logic [31:0]     px;
        logic [6:0]      cnt;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = tip_pkg::REG_INTERP;
        cfg_data       = '0;
        push           = 1'b0;
        kind           = tip_pkg::KIND_LOAD;
        entry_index    = '0;
        point_x        = '0;
        point_y        = '0;
        query_x        = '0;
        pop            = 1'b0;
        failed         = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        cycle_count    = 0;
        cur_interp     = tip_pkg::INTERP_LINEAR;
        cur_extrap     = tip_pkg::EXTRAP_HOLD;
        cur_count      = '0;
        for (i = 0; i < tip_pkg::MAX_POINTS; i++)
        begin
            tbl_x[i]   = '0;
            tbl_y[i]   = '0;
            written[i] = 1'b0;
        end

        // directed table: empty table, load order, one-point table, interval ends,
        // saturated extrapolation, flags, unused mode codes, disordered table
        directed_rows = '{
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_LINEAR, tip_pkg::EXTRAP_HOLD, 32'd0,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'd0, 1'b1, 32'd0, tip_pkg::ST_EMPTY},
            '{ROW_LOAD,  6'd0, X_MIN, X_MAX, '0, 1'b1, 32'd0, tip_pkg::ST_OK},
            '{ROW_LOAD,  6'd1, X_MIN, 32'd0, '0, 1'b1, 32'd0, tip_pkg::ST_ORDER},
            '{ROW_LOAD,  6'd1, 32'd0, X_MIN, '0, 1'b1, 32'd0, tip_pkg::ST_OK},
            '{ROW_LOAD,  6'd2, X_MAX, 32'd0, '0, 1'b1, 32'd0, tip_pkg::ST_OK},
            '{ROW_LOAD,  6'd3, X_MAX, 32'd5, '0, 1'b1, 32'd0, tip_pkg::ST_ORDER},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_LINEAR, tip_pkg::EXTRAP_FLAG, 32'd1,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, X_MIN, 1'b1, X_MAX, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'd5, 1'b1, 32'd0, tip_pkg::ST_RANGE},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_UPPER, tip_pkg::EXTRAP_HOLD, 32'd1,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'd5, 1'b1, X_MAX, tip_pkg::ST_OK},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_LINEAR, tip_pkg::EXTRAP_HOLD, 32'd3,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, X_MIN, 1'b1, X_MAX, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, X_MAX, 1'b1, 32'd0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'd0, 1'b1, X_MIN, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'hffff_ffff, 1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'h4000_0000, 1'b0, '0, tip_pkg::ST_OK},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_LOWER, tip_pkg::EXTRAP_HOLD, 32'd3,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'hffff_ffff, 1'b0, '0, tip_pkg::ST_OK},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_UPPER, tip_pkg::EXTRAP_HOLD, 32'd3,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'hffff_ffff, 1'b0, '0, tip_pkg::ST_OK},
            // steep two-point table for saturation
            '{ROW_LOAD,  6'd0, 32'hffff_0000, 32'h7fff_0000, '0, 1'b1, 32'd0, tip_pkg::ST_OK},
            '{ROW_LOAD,  6'd1, 32'd0, 32'h8001_0000, '0, 1'b1, 32'd0, tip_pkg::ST_OK},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_LINEAR, tip_pkg::EXTRAP_LINEAR, 32'd2,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, X_MIN, 1'b1, X_MAX, tip_pkg::ST_SATURATED},
            '{ROW_QUERY, 6'd0, '0, '0, X_MAX, 1'b1, X_MIN, tip_pkg::ST_SATURATED},
            '{ROW_QUERY, 6'd0, '0, '0, 32'hffff_8000, 1'b0, '0, tip_pkg::ST_OK},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_LINEAR, tip_pkg::EXTRAP_FLAG, 32'd2,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, X_MAX, 1'b1, 32'd0, tip_pkg::ST_RANGE},
            // mode code 3 behaves as linear / hold
            '{ROW_CFG,   6'd0, 32'd3, 32'd3, 32'd2, 1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, X_MAX, 1'b1, 32'h8001_0000, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'hffff_8000, 1'b0, '0, tip_pkg::ST_OK},
            // entry 0 rewritten above entry 1: disordered table
            '{ROW_LOAD,  6'd0, 32'h0001_0000, 32'h0000_1234, '0, 1'b1, 32'd0, tip_pkg::ST_OK},
            '{ROW_CFG,   6'd0, tip_pkg::INTERP_LINEAR, tip_pkg::EXTRAP_LINEAR, 32'd2,
              1'b0, '0, tip_pkg::ST_OK},
            '{ROW_QUERY, 6'd0, '0, '0, 32'h0000_8000, 1'b0, '0, tip_pkg::ST_OK}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_DIRECTED; r++)
        begin
            case (directed_rows[r].rk)
                ROW_CFG:
                    set_config(directed_rows[r].a[1:0], directed_rows[r].b[1:0],
                               directed_rows[r].c[6:0]);
                ROW_LOAD:
                    send_request(tip_pkg::KIND_LOAD, directed_rows[r].idx, directed_rows[r].a,
                                 directed_rows[r].b, $urandom, directed_rows[r].known,
                                 directed_rows[r].val, directed_rows[r].st);
                default:
                    send_request(KIND_QUERY, directed_rows[r].idx, $urandom, $urandom,
                                 directed_rows[r].c, directed_rows[r].known,
                                 directed_rows[r].val, directed_rows[r].st);
            endcase
        end

        // random phases: rebuild a well-formed table, set the registers, then mostly
        // queries with some stray loads mixed in
        for (ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase

            if (ph == 5 || ph == 10)
                k = tip_pkg::MAX_POINTS;
            else if (ph == 9)
                k = 1;
            else
                k = $urandom_range(2, 12);

            // strictly increasing x, spacing from tiny to nearly full range
            step_max = (32'hffff_ffff / (k + 1)) >> $urandom_range(0, 24);
            if (step_max == 0)
                step_max = 1;
            slack = 64'hffff_ffff - longint'(k + 1) * step_max;
            cur_x = VAL_MIN + $urandom_range(0, slack[31:0]);
            for (i = 0; i < k; i++)
            begin
                cur_x += $urandom_range(1, step_max);
                px = cur_x[31:0];
                send_request(tip_pkg::KIND_LOAD, i[5:0], px,
                             $urandom_range(0, 1) ? $urandom : ($urandom >> 12), $urandom);
            end

            if (ph == 5)
                cnt = 7'd127;
            else if ($urandom_range(0, 5) == 0)
                cnt = 7'($urandom_range(0, k));
            else
                cnt = 7'(k);
            set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), cnt);

            // long receiver hold-off so the request side backs up and asserts full
            if (ph == 2)
                hold_request++;

            for (j = 0; j < 90; j++)
            begin
                if (ph == 3 && j == 45)
                    drain();
                if ($urandom_range(99) < 85)
                begin
                    n = (cur_count > tip_pkg::MAX_POINTS) ? tip_pkg::MAX_POINTS : cur_count;
                    if (n == 0)
                    begin
                        qx = $urandom;
                    end
                    else
                    begin
                        i = $urandom_range(0, n - 1);
                        case ($urandom_range(0, 7))
                            0: qx = tbl_x[i];
                            1, 2, 3: qx = tbl_x[i] + ($urandom >> $urandom_range(1, 31));
                            4: qx = tbl_x[0] - ($urandom >> $urandom_range(1, 31));
                            5: qx = tbl_x[n - 1] + ($urandom >> $urandom_range(1, 31));
                            6: qx = $urandom;
                            default: qx = $urandom_range(0, 1) ? X_MIN : X_MAX;
                        endcase
                    end
                    send_request(KIND_QUERY, 6'($urandom), $urandom, $urandom, qx);
                end
                else
                begin
                    // stray load: only where the previous entry is already written
                    lim = written_prefix();
                    if (lim > tip_pkg::MAX_POINTS - 1)
                        lim = tip_pkg::MAX_POINTS - 1;
                    i = $urandom_range(0, lim);
                    if (i > 0 && $urandom_range(0, 1))
                        px = tbl_x[i - 1] + ($urandom >> $urandom_range(8, 31));
                    else
                        px = $urandom;
                    send_request(tip_pkg::KIND_LOAD, i[5:0], px, $urandom, $urandom);
                end
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("table_interpolator_1d regression: pass");
        else
            $display("table_interpolator_1d regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tip_pkg.sv
sv/tip_front.sv
sv/tip_cmd_queue.sv
sv/tip_back.sv
sv/table_interpolator_1d.sv
bench/tb.sv
